FILE: sv/lmcm_pkg.sv
// ----------------------------------------------------------------------------
// lmcm_pkg
// Shared types and constants of the label map contour marker.
// ----------------------------------------------------------------------------
`default_nettype none

package lmcm_pkg;

  // payload widths of the pixel channels
  localparam int unsigned LABEL_IN_BITS = 16;
  localparam int unsigned CHAN_BITS     = 8;

  // configuration registers
  localparam int unsigned FW_BITS       = 11;
  localparam int unsigned FH_BITS       = 13;
  localparam int unsigned ROW_BITS      = FH_BITS + 1;
  localparam int unsigned APB_ADDR_BITS = 3;
  localparam int unsigned APB_DATA_BITS = 32;

  localparam logic [FW_BITS-1:0] FW_RESET = FW_BITS'(640);
  localparam logic [FH_BITS-1:0] FH_RESET = FH_BITS'(480);

  // defaults of the top-level parameters
  localparam int unsigned MAX_WIDTH_DEF  = 1024;
  localparam int unsigned LABEL_BITS_DEF = 16;

  // contour paint colour
  localparam logic [CHAN_BITS-1:0] PAINT_BLUE  = 8'h26;
  localparam logic [CHAN_BITS-1:0] PAINT_GREEN = 8'hfb;
  localparam logic [CHAN_BITS-1:0] PAINT_RED   = 8'hff;

  typedef enum logic {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_e;

  // which neighbours of the window centre lie inside the frame, plus the frame-end flag
  typedef struct packed {
    logic up_ok;
    logic mid_ok;
    logic dn_ok;
    logic lf_ok;
    logic rt_ok;
    logic done;
  } win_ctl_t;

endpackage

`default_nettype wire

FILE: sv/lmcm_in_if.sv
// ----------------------------------------------------------------------------
// lmcm_in_if
// Pixel input channel: valid/ready handshake with label and colour.
// ----------------------------------------------------------------------------
`default_nettype none

interface lmcm_in_if;
  import lmcm_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     is_pad;
  logic [LABEL_IN_BITS-1:0] region_label;
  logic [CHAN_BITS-1:0]     in_blue;
  logic [CHAN_BITS-1:0]     in_green;
  logic [CHAN_BITS-1:0]     in_red;

  modport source (
    output valid, is_pad, region_label, in_blue, in_green, in_red,
    input  ready
  );

  modport sink (
    input  valid, is_pad, region_label, in_blue, in_green, in_red,
    output ready
  );

endinterface

`default_nettype wire

FILE: sv/lmcm_out_if.sv
// ----------------------------------------------------------------------------
// lmcm_out_if
// Result channel: valid/ready handshake with painted colour and flags.
// ----------------------------------------------------------------------------
`default_nettype none

interface lmcm_out_if;
  import lmcm_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CHAN_BITS-1:0] out_blue;
  logic [CHAN_BITS-1:0] out_green;
  logic [CHAN_BITS-1:0] out_red;
  logic                 on_contour;
  logic                 frame_end;

  modport source (
    output valid, out_blue, out_green, out_red, on_contour, frame_end,
    input  ready
  );

  modport sink (
    input  valid, out_blue, out_green, out_red, on_contour, frame_end,
    output ready
  );

endinterface

`default_nettype wire

FILE: sv/label_map_contour_marker.sv
// ----------------------------------------------------------------------------
// label_map_contour_marker
// Takes one raster pixel (region label and colour) per clock and marks the
// pixels that lie on a border between regions. Two label line buffers (one
// bank per row parity) and one colour line buffer feed a 3x3 label window;
// a pixel with more than one in-frame neighbour of a different label is
// repainted blue 0x26, green 0xfb, red 0xff, any other keeps its colour. An
// item is taken every cycle while the output is free or being drained: the
// line buffer read happens at the accepting edge, the window compare sits in
// the next cycle, and the result register follows. A pixel's result comes
// out frame_width+1 items after the pixel, so frame_width+1 pad items after
// the last pixel flush the frame; frame_end marks the last result. Line
// buffers need no clearing after reset. Writing frame_width or frame_height
// restarts the frame position; write them only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module label_map_contour_marker #(
  parameter int unsigned MAX_WIDTH  = lmcm_pkg::MAX_WIDTH_DEF,
  parameter int unsigned LABEL_BITS = lmcm_pkg::LABEL_BITS_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  lmcm_in_if.sink                                 in_i,
  lmcm_out_if.source                              out_o,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [lmcm_pkg::APB_ADDR_BITS-1:0] paddr,
  input  wire logic [lmcm_pkg::APB_DATA_BITS-1:0] pwdata,
  output logic      [lmcm_pkg::APB_DATA_BITS-1:0] prdata,
  output logic                                    pready
);
  import lmcm_pkg::*;

  localparam int unsigned CW  = $clog2(MAX_WIDTH);
  localparam int unsigned WW  = $clog2(MAX_WIDTH + 1);
  localparam int unsigned WX  = WW + 1;
  localparam int unsigned WC  = (WW > FW_BITS) ? WW : FW_BITS;
  localparam int unsigned RX  = ROW_BITS + 1;
  localparam int unsigned LCP = (LABEL_BITS < LABEL_IN_BITS) ? LABEL_BITS : LABEL_IN_BITS;
  localparam int unsigned PXB = 3 * CHAN_BITS;

  // configuration
  logic [FW_BITS-1:0] fw_q;
  logic [FH_BITS-1:0] fh_q;
  logic               cfg_wr;
  cfg_reg_e           cfg_sel;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_sel = cfg_reg_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q <= FW_RESET;
      fh_q <= FH_RESET;
    end else if (cfg_wr) begin
      case (cfg_sel)
        REG_FRAME_WIDTH:  fw_q <= pwdata[FW_BITS-1:0];
        REG_FRAME_HEIGHT: fh_q <= pwdata[FH_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_sel)
      REG_FRAME_WIDTH:  prdata = APB_DATA_BITS'(fw_q);
      REG_FRAME_HEIGHT: prdata = APB_DATA_BITS'(fh_q);
      default:          prdata = '0;
    endcase
  end

  // effective frame size
  logic [WC-1:0]      fw_c;
  logic [WW-1:0]      weff;
  logic [FH_BITS-1:0] heff;

  always_comb begin
    fw_c = WC'(fw_q);
    if (fw_c == '0) begin
      weff = WW'(1);
    end else if (fw_c > WC'(MAX_WIDTH)) begin
      weff = WW'(MAX_WIDTH);
    end else begin
      weff = WW'(fw_c);
    end
    heff = (fh_q == '0) ? FH_BITS'(1) : fh_q;
  end

  // frame position and item decode
  logic [CW-1:0]       col_q;
  logic [ROW_BITS-1:0] row_q;
  logic                acc, flush, proc, done, wrap, has_res;
  logic [ROW_BITS-1:0] cy;
  logic [LABEL_BITS-1:0] lab;
  logic [PXB-1:0]      pix;
  win_ctl_t            ctl;

  assign acc   = in_i.valid & in_i.ready;
  assign flush = row_q >= ROW_BITS'(heff);
  assign proc  = acc & (flush | ~in_i.is_pad);
  assign done  = (row_q == ROW_BITS'(heff) + ROW_BITS'(1)) && (col_q == '0);
  assign wrap  = (WX'(col_q) + WX'(1)) >= WX'(weff);

  always_comb begin
    lab = '0;
    if (!flush) begin
      lab[LCP-1:0] = in_i.region_label[LCP-1:0];
    end
    pix = flush ? '0 : {in_i.in_red, in_i.in_green, in_i.in_blue};
  end

  // centre sits one column back, or at the end of the row before last
  always_comb begin
    if (col_q != '0) begin
      cy      = row_q - ROW_BITS'(1);
      has_res = row_q != '0;
      ctl.lf_ok = col_q >= CW'(2);
      ctl.rt_ok = 1'b1;
    end else begin
      cy      = row_q - ROW_BITS'(2);
      has_res = row_q >= ROW_BITS'(2);
      ctl.lf_ok = weff >= WW'(2);
      ctl.rt_ok = 1'b0;
    end
    ctl.up_ok  = cy != '0;
    ctl.mid_ok = cy < ROW_BITS'(heff);
    ctl.dn_ok  = (RX'(cy) + RX'(1)) < RX'(heff);
    ctl.done   = done;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (cfg_wr) begin
      col_q <= '0;
      row_q <= '0;
    end else if (proc) begin
      if (done) begin
        col_q <= '0;
        row_q <= '0;
      end else if (wrap) begin
        col_q <= '0;
        row_q <= row_q + ROW_BITS'(1);
      end else begin
        col_q <= col_q + CW'(1);
      end
    end
  end

  // line buffers
  logic [LABEL_BITS-1:0] lbuf0 [MAX_WIDTH];
  logic [LABEL_BITS-1:0] lbuf1 [MAX_WIDTH];
  logic [PXB-1:0]        cbuf  [MAX_WIDTH];

  always_ff @(posedge clk_i) begin
    if (proc) begin
      if (row_q[0]) begin
        lbuf1[col_q] <= lab;
      end else begin
        lbuf0[col_q] <= lab;
      end
      cbuf[col_q] <= pix;
    end
  end

  // window: two shifted columns plus the newest column from the buffer reads
  logic [LABEL_BITS-1:0] rd0_q, rd1_q, lab_q;
  logic                  sel_q;
  logic [PXB-1:0]        hold_q, cent_q;
  logic [LABEL_BITS-1:0] wc0_q [3];
  logic [LABEL_BITS-1:0] wc1_q [3];
  logic [LABEL_BITS-1:0] top, mid;

  assign top = sel_q ? rd1_q : rd0_q;
  assign mid = sel_q ? rd0_q : rd1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd0_q  <= '0;
      rd1_q  <= '0;
      lab_q  <= '0;
      sel_q  <= 1'b0;
      hold_q <= '0;
      cent_q <= '0;
      for (int i = 0; i < 3; i++) begin
        wc0_q[i] <= '0;
        wc1_q[i] <= '0;
      end
    end else if (proc) begin
      rd0_q    <= lbuf0[col_q];
      rd1_q    <= lbuf1[col_q];
      sel_q    <= row_q[0];
      lab_q    <= lab;
      hold_q   <= cbuf[col_q];
      cent_q   <= hold_q;
      wc0_q    <= wc1_q;
      wc1_q[0] <= top;
      wc1_q[1] <= mid;
      wc1_q[2] <= lab_q;
    end
  end

  // compare stage
  logic     a_valid_q;
  win_ctl_t a_ctl_q;
  logic     a_adv;

  assign a_adv      = a_valid_q & (~out_o.valid | out_o.ready);
  assign in_i.ready = ~a_valid_q | ~out_o.valid | out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (proc) begin
      a_valid_q <= has_res;
    end else if (a_adv) begin
      a_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc) begin
      a_ctl_q <= ctl;
    end
  end

  logic [LABEL_BITS-1:0] centre;
  logic [7:0]            diff;
  logic                  contour;

  always_comb begin
    centre  = wc1_q[1];
    diff[0] = a_ctl_q.up_ok  & a_ctl_q.lf_ok & (wc0_q[0] != centre);
    diff[1] = a_ctl_q.up_ok                  & (wc1_q[0] != centre);
    diff[2] = a_ctl_q.up_ok  & a_ctl_q.rt_ok & (top      != centre);
    diff[3] = a_ctl_q.mid_ok & a_ctl_q.lf_ok & (wc0_q[1] != centre);
    diff[4] = a_ctl_q.mid_ok & a_ctl_q.rt_ok & (mid      != centre);
    diff[5] = a_ctl_q.dn_ok  & a_ctl_q.lf_ok & (wc0_q[2] != centre);
    diff[6] = a_ctl_q.dn_ok                  & (wc1_q[2] != centre);
    diff[7] = a_ctl_q.dn_ok  & a_ctl_q.rt_ok & (lab_q    != centre);
    // more than one bit set
    contour = (diff & (diff - 8'd1)) != 8'd0;
  end

  // result register
  logic                 o_valid_q;
  logic [CHAN_BITS-1:0] o_blue_q, o_green_q, o_red_q;
  logic                 o_contour_q, o_end_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_valid_q <= 1'b0;
    end else if (a_adv) begin
      o_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      o_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_adv) begin
      if (contour) begin
        o_blue_q  <= PAINT_BLUE;
        o_green_q <= PAINT_GREEN;
        o_red_q   <= PAINT_RED;
      end else begin
        o_blue_q  <= cent_q[CHAN_BITS-1:0];
        o_green_q <= cent_q[2*CHAN_BITS-1:CHAN_BITS];
        o_red_q   <= cent_q[PXB-1:2*CHAN_BITS];
      end
      o_contour_q <= contour;
      o_end_q     <= a_ctl_q.done;
    end
  end

  assign out_o.valid      = o_valid_q;
  assign out_o.out_blue   = o_blue_q;
  assign out_o.out_green  = o_green_q;
  assign out_o.out_red    = o_red_q;
  assign out_o.on_contour = o_contour_q;
  assign out_o.frame_end  = o_end_q;

endmodule

`default_nettype wire
